// ----- hw/rtl/dedup_expiry_timer_table_core_defines.svh -----
// Assertion macros for the timeout table core.
// The module that uses them has aclk and aresetn in scope.
`ifndef DEDUP_EXPIRY_TIMER_TABLE_CORE_DEFINES_SVH
`define DEDUP_EXPIRY_TIMER_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define DETC_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("timeout table assertion failed");

// next-cycle implication
`define DETC_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("timeout table assertion failed");

`endif

// ----- hw/rtl/detc_pkg.sv -----
`timescale 1ns / 1ps

package detc_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 2;
    localparam int TIME_W   = 16;
    localparam int COORD_W  = 16;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 3;
    localparam int ACT_W    = 7;

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(CAPACITY - 1);
    localparam logic [TIME_W-1:0] HOLD_RESET = 16'd500;

    localparam logic [OP_W-1:0] OP_ADVANCE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [TIME_W-1:0]         elapsed;
        logic signed [COORD_W-1:0] cell_x;
        logic signed [COORD_W-1:0] cell_y;
        logic [IDX_W-1:0]          index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [TIME_W-1:0]         remaining;
        logic [ACT_W-1:0]          active_count;
        logic                      last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TIME_W-1:0]         time_left;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    typedef struct packed {
        logic load_item;
        logic scan_start;
        logic scan_run;
        logic expire_pass;
        logic commit;
        logic emit_single;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic age_needed;
        logic expire_needed;
        logic can_emit;
    } sts_t;

endpackage

// ----- hw/rtl/dedup_expiry_timer_table_core.sv -----
`timescale 1ns / 1ps
// Channel  | Ports                        | Moves
// ---------+------------------------------+-----------------------------------
// input    | s_valid s_ready s_data       | one request: advance/schedule/query
// result   | m_valid m_ready m_data       | results, last marks end of a request
// config   | cfg_valid cfg_ready cfg_data | hold_time write, ready out of reset
//
// Schedule, query and unused codes sweep the slots once before their result; an
// advance sweeps them twice, with a separate result state when nothing
// expires. The slot RAM read port reads one slot per cycle unless a result stalls.
// Reset (synchronous, aresetn low) clears all slots, sets hold_time to 500 and
// holds both ready outputs low. A stalled result channel holds the sweep on the
// expiring slot; one request is in work at a time, its last result may wait.

module dedup_expiry_timer_table_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  detc_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output detc_pkg::out_item_t         m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [detc_pkg::TIME_W-1:0] cfg_data
);

    import detc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    detc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    detc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- hw/rtl/detc_ram.sv -----
`timescale 1ns / 1ps

module detc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/detc_ctrl.sv -----
`timescale 1ns / 1ps

module detc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  detc_pkg::sts_t sts,
    output detc_pkg::cmd_t cmd
);

    import detc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_EXPIRE = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == S_IDLE) && aresetn;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load_item  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.commit = 1'b1;
                if (sts.age_needed) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_EXPIRE;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_EXPIRE: begin
                cmd.scan_run    = 1'b1;
                cmd.expire_pass = 1'b1;
                if (sts.scan_last) begin
                    if (sts.expire_needed) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (sts.can_emit) begin
                    cmd.emit_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/detc_dp.sv -----
`timescale 1ns / 1ps
`include "dedup_expiry_timer_table_core_defines.svh"

module detc_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  detc_pkg::in_item_t            s_data,
    output detc_pkg::out_item_t           m_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [detc_pkg::TIME_W-1:0]   cfg_data,
    input  detc_pkg::cmd_t                cmd,
    output detc_pkg::sts_t                sts
);

    import detc_pkg::*;

    logic [TIME_W-1:0]   hold_reg;
    in_item_t            item_reg;
    logic [CAPACITY-1:0] valid_reg;
    logic [CNT_W-1:0]    act_reg;

    // slot sweep: read address stage and returned data stage
    logic [SLOT_W-1:0]   addr_reg;
    logic                issue_reg;
    logic                dv_reg;
    logic [SLOT_W-1:0]   didx_reg;

    logic                dup_reg;
    logic                free_found_reg;
    logic [SLOT_W-1:0]   free_idx_reg;
    logic                hit_reg;
    slot_t               hit_data_reg;
    logic [CNT_W-1:0]    seen_reg;
    logic [CNT_W-1:0]    exp_cnt_reg;
    logic [CNT_W-1:0]    left_reg;

    logic                out_valid_reg;
    out_item_t           out_reg;

    slot_t               rd_slot;
    slot_t               wr_slot;
    logic [SLOT_BITS-1:0] rd_raw;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;

    logic                cur_valid;
    logic                expiring;
    logic                key_match;
    logic                can_emit;
    logic                stall;
    logic                proceed;
    logic                exp_emit;
    logic                sched_write;
    logic                age_write;
    logic                out_load;
    out_item_t           single_res;
    out_item_t           out_next;

    detc_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_slot),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_slot   = rd_raw;
    assign cfg_ready = aresetn;

    assign cur_valid = valid_reg[didx_reg];
    assign expiring  = (item_reg.elapsed >= rd_slot.time_left);
    assign key_match = (rd_slot.x == item_reg.cell_x) && (rd_slot.y == item_reg.cell_y);
    assign can_emit  = !out_valid_reg || m_ready;

    // an expiring slot waits on a full output register by re-reading itself
    assign stall     = cmd.expire_pass && dv_reg && cur_valid && expiring && !can_emit;
    assign proceed   = cmd.scan_run && dv_reg && !stall;
    assign exp_emit  = cmd.expire_pass && proceed && cur_valid && expiring;
    assign age_write = cmd.expire_pass && proceed && cur_valid && !expiring;
    assign sched_write = cmd.commit && (item_reg.operation == OP_SCHEDULE)
                         && !dup_reg && free_found_reg;

    assign rd_en   = cmd.scan_run && (stall || issue_reg);
    assign rd_addr = stall ? didx_reg : addr_reg;
    assign wr_en   = sched_write || age_write;
    assign wr_addr = sched_write ? free_idx_reg : didx_reg;

    always_comb begin
        if (sched_write) begin
            wr_slot.x         = item_reg.cell_x;
            wr_slot.y         = item_reg.cell_y;
            wr_slot.time_left = hold_reg;
        end else begin
            wr_slot.x         = rd_slot.x;
            wr_slot.y         = rd_slot.y;
            wr_slot.time_left = rd_slot.time_left - item_reg.elapsed;
        end
    end

    always_comb begin
        single_res              = '0;
        single_res.active_count = ACT_W'(act_reg);
        single_res.last         = 1'b1;
        unique case (item_reg.operation)
            OP_ADVANCE: begin
                single_res.status = ST_NONE;
            end
            OP_SCHEDULE: begin
                if (dup_reg) begin
                    single_res.status = ST_DUP;
                end else if (free_found_reg) begin
                    single_res.status = ST_ADDED;
                end else begin
                    single_res.status = ST_FULL;
                end
            end
            OP_QUERY: begin
                if (hit_reg) begin
                    single_res.status    = ST_HIT;
                    single_res.out_x     = hit_data_reg.x;
                    single_res.out_y     = hit_data_reg.y;
                    single_res.remaining = hit_data_reg.time_left;
                end else begin
                    single_res.status = ST_MISS;
                end
            end
            default: begin
                single_res.status = ST_NONE;
            end
        endcase
    end

    always_comb begin
        if (exp_emit) begin
            out_next.status       = ST_EXPIRED;
            out_next.out_x        = rd_slot.x;
            out_next.out_y        = rd_slot.y;
            out_next.remaining    = '0;
            out_next.active_count = ACT_W'(act_reg);
            out_next.last         = (left_reg == CNT_W'(1));
        end else begin
            out_next = single_res;
        end
    end

    assign out_load = exp_emit || cmd.emit_single;

    assign sts.scan_last     = proceed && (didx_reg == LAST_SLOT);
    assign sts.age_needed    = (item_reg.operation == OP_ADVANCE);
    assign sts.expire_needed = (item_reg.operation == OP_ADVANCE) && (exp_cnt_reg != '0);
    assign sts.can_emit      = can_emit;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg      <= HOLD_RESET;
            valid_reg     <= '0;
            act_reg       <= '0;
            addr_reg      <= '0;
            issue_reg     <= 1'b0;
            dv_reg        <= 1'b0;
            didx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                hold_reg <= cfg_data;
            end

            if (sched_write) begin
                valid_reg[free_idx_reg] <= 1'b1;
                act_reg                 <= act_reg + CNT_W'(1);
            end else if (cmd.commit && sts.expire_needed) begin
                act_reg <= act_reg - exp_cnt_reg;
            end
            if (exp_emit) begin
                valid_reg[didx_reg] <= 1'b0;
            end

            if (cmd.scan_start) begin
                addr_reg  <= '0;
                issue_reg <= 1'b1;
                dv_reg    <= 1'b0;
            end else if (cmd.scan_run && !stall) begin
                dv_reg   <= issue_reg;
                didx_reg <= addr_reg;
                if (issue_reg) begin
                    if (addr_reg == LAST_SLOT) begin
                        issue_reg <= 1'b0;
                    end else begin
                        addr_reg <= addr_reg + SLOT_W'(1);
                    end
                end
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg       <= s_data;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            seen_reg       <= '0;
            exp_cnt_reg    <= '0;
        end else if (proceed && !cmd.expire_pass) begin
            if (cur_valid) begin
                if ((item_reg.operation == OP_ADVANCE) && expiring) begin
                    exp_cnt_reg <= exp_cnt_reg + CNT_W'(1);
                end
                if ((item_reg.operation == OP_SCHEDULE) && key_match) begin
                    dup_reg <= 1'b1;
                end
                if (item_reg.operation == OP_QUERY) begin
                    if (!hit_reg && (8'(seen_reg) == 8'(item_reg.index))) begin
                        hit_reg      <= 1'b1;
                        hit_data_reg <= rd_slot;
                    end
                    seen_reg <= seen_reg + CNT_W'(1);
                end
            end else if ((item_reg.operation == OP_SCHEDULE) && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= didx_reg;
            end
        end

        if (cmd.commit) begin
            left_reg <= exp_cnt_reg;
        end else if (exp_emit) begin
            left_reg <= left_reg - CNT_W'(1);
        end

        if (out_load) begin
            out_reg <= out_next;
        end
    end

    `DETC_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_reg || m_ready)
    `DETC_ASSERT_IMP(a_count_bound, 1'b1, act_reg <= CNT_W'(CAPACITY))
    `DETC_ASSERT_IMP(a_expire_budget, exp_emit, left_reg != '0)
    `DETC_ASSERT_IMP(a_sched_free, sched_write, !valid_reg[free_idx_reg])
    `DETC_ASSERT_NXT(a_emit_shown, exp_emit, out_valid_reg)

endmodule

// ----- sim/tb_dedup_expiry_timer_table_core.sv -----
`timescale 1ns / 1ps

module tb_dedup_expiry_timer_table_core;
    import detc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int              CYCLE_LIMIT = 1000000;
    localparam int              END_PAUSE   = 2 * CAPACITY + 10;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TIME_W-1:0]   cfg_data  = '0;

    // mirror of the slot table
    logic                      tbl_valid [CAPACITY];
    logic signed [COORD_W-1:0] tbl_x     [CAPACITY];
    logic signed [COORD_W-1:0] tbl_y     [CAPACITY];
    logic [TIME_W-1:0]         tbl_time  [CAPACITY];
    logic [TIME_W-1:0]         hold_cfg;

    out_item_t pending_results[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int hold_writes    = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    dedup_expiry_timer_table_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        for (int s = 0; s < CAPACITY; s++) begin
            tbl_valid[s] = 1'b0;
            tbl_x[s]     = '0;
            tbl_y[s]     = '0;
            tbl_time[s]  = '0;
        end
        hold_cfg = HOLD_RESET;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL dedup_expiry_timer_table_core");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d", m_data.status));
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_data.status, want.status));
                if (m_data.out_x !== want.out_x)
                    report_mismatch($sformatf("out_x %0d, want %0d",
                                              m_data.out_x, want.out_x));
                if (m_data.out_y !== want.out_y)
                    report_mismatch($sformatf("out_y %0d, want %0d",
                                              m_data.out_y, want.out_y));
                if (m_data.remaining !== want.remaining)
                    report_mismatch($sformatf("remaining %0d, want %0d",
                                              m_data.remaining, want.remaining));
                if (m_data.active_count !== want.active_count)
                    report_mismatch($sformatf("active_count %0d, want %0d",
                                              m_data.active_count, want.active_count));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              m_data.last, want.last));
            end
        end
    end

    function automatic int active_entries();
        int n;
        n = 0;
        for (int s = 0; s < CAPACITY; s++)
            if (tbl_valid[s])
                n++;
        return n;
    endfunction

    task automatic predict_table_step(input in_item_t req);
        out_item_t step_q[$];
        out_item_t r;
        bit        found;
        int        seen;
        int        slot;
        int        cnt;
        found = 1'b0;
        seen  = 0;
        slot  = -1;
        case (req.operation)
            OP_ADVANCE: begin
                for (int s = 0; s < CAPACITY; s++) begin
                    if (tbl_valid[s]) begin
                        if (req.elapsed >= tbl_time[s]) begin
                            tbl_valid[s] = 1'b0;
                            r        = '0;
                            r.status = ST_EXPIRED;
                            r.out_x  = tbl_x[s];
                            r.out_y  = tbl_y[s];
                            step_q.push_back(r);
                        end else begin
                            tbl_time[s] = tbl_time[s] - req.elapsed;
                        end
                    end
                end
                if (step_q.size() == 0) begin
                    r        = '0;
                    r.status = ST_NONE;
                    step_q.push_back(r);
                end
            end
            OP_SCHEDULE: begin
                r = '0;
                for (int s = 0; s < CAPACITY; s++)
                    if (tbl_valid[s] && tbl_x[s] == req.cell_x && tbl_y[s] == req.cell_y)
                        found = 1'b1;
                for (int s = CAPACITY - 1; s >= 0; s--)
                    if (!tbl_valid[s])
                        slot = s;
                if (found) begin
                    r.status = ST_DUP;
                end else if (slot >= 0) begin
                    tbl_valid[slot] = 1'b1;
                    tbl_x[slot]     = req.cell_x;
                    tbl_y[slot]     = req.cell_y;
                    tbl_time[slot]  = hold_cfg;
                    r.status        = ST_ADDED;
                end else begin
                    r.status = ST_FULL;
                end
                step_q.push_back(r);
            end
            OP_QUERY: begin
                r        = '0;
                r.status = ST_MISS;
                for (int s = 0; s < CAPACITY; s++) begin
                    if (tbl_valid[s] && !found) begin
                        if (seen == req.index) begin
                            r.status    = ST_HIT;
                            r.out_x     = tbl_x[s];
                            r.out_y     = tbl_y[s];
                            r.remaining = tbl_time[s];
                            found       = 1'b1;
                        end
                        seen++;
                    end
                end
                step_q.push_back(r);
            end
            default: begin
                r        = '0;
                r.status = ST_NONE;
                step_q.push_back(r);
            end
        endcase
        cnt = active_entries();
        foreach (step_q[k]) begin
            step_q[k].active_count = ACT_W'(cnt);
            step_q[k].last         = (k == step_q.size() - 1);
            pending_results.push_back(step_q[k]);
        end
    endtask

    function automatic in_item_t make_request(input logic [OP_W-1:0] op,
                                              input logic [TIME_W-1:0] elapsed,
                                              input logic signed [COORD_W-1:0] x,
                                              input logic signed [COORD_W-1:0] y,
                                              input logic [IDX_W-1:0] idx);
        in_item_t req;
        req.operation = op;
        req.elapsed   = elapsed;
        req.cell_x    = x;
        req.cell_y    = y;
        req.index     = idx;
        return req;
    endfunction

    function automatic in_item_t random_request();
        in_item_t req;
        int       pick;
        int       cnt;
        req  = in_item_t'({$urandom(), $urandom(), $urandom()});
        pick = $urandom_range(0, 99);
        cnt  = active_entries();
        if (pick < 40) begin
            req.operation = OP_SCHEDULE;
            if ($urandom_range(0, 3) != 0) begin
                req.cell_x = COORD_W'($signed($urandom_range(0, 6)) - 3);
                req.cell_y = COORD_W'($signed($urandom_range(0, 6)) - 3);
            end
        end else if (pick < 70) begin
            req.operation = OP_ADVANCE;
            if ($urandom_range(0, 4) != 0)
                req.elapsed = TIME_W'($urandom_range(0, 120));
        end else if (pick < 95) begin
            req.operation = OP_QUERY;
            if ($urandom_range(0, 4) != 0)
                req.index = IDX_W'((cnt > 62) ? $urandom_range(0, 63) : $urandom_range(0, cnt));
        end else begin
            req.operation = OP_UNUSED;
        end
        return req;
    endfunction

    // caller is at a falling edge; returns at a falling edge
    task automatic send_request(input in_item_t req);
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge aclk);
        s_data  = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_table_step(req);
        requests_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // the slot sweep may run on after the last result
    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (CAPACITY + 8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_hold_time(input logic [TIME_W-1:0] value);
        wait_results_drained();
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        hold_cfg = value;
        hold_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_pace(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic test_empty_and_unused();
        send_request(make_request(OP_QUERY, 16'h0, 16'sh0, 16'sh0, 6'd0));
        send_request(make_request(OP_ADVANCE, 16'h0, 16'sh0, 16'sh0, 6'd0));
        send_request(make_request(OP_UNUSED, 16'hFFFF, -16'sd1, -16'sd1, 6'h3F));
        send_request(make_request(OP_UNUSED, 16'h0, 16'sh0, 16'sh0, 6'd0));
    endtask

    task automatic test_schedule_query();
        send_request(make_request(OP_SCHEDULE, 16'h0, 16'sh7FFF, 16'sh8000, 6'd0));
        send_request(make_request(OP_SCHEDULE, 16'h0, 16'sh8000, 16'sh7FFF, 6'd0));
        send_request(make_request(OP_SCHEDULE, 16'h0, 16'sh7FFF, 16'sh8000, 6'd0));
        send_request(make_request(OP_SCHEDULE, 16'h0, 16'sh0, 16'sh0, 6'd0));
        send_request(make_request(OP_QUERY, 16'h0, 16'sh0, 16'sh0, 6'd0));
        send_request(make_request(OP_QUERY, 16'h0, 16'sh0, 16'sh0, 6'd2));
        send_request(make_request(OP_QUERY, 16'h0, 16'sh0, 16'sh0, 6'h3F));
        send_request(make_request(OP_QUERY, 16'h0, 16'sh0, 16'sh0, 6'd3));
        send_request(make_request(OP_ADVANCE, 16'd499, 16'sh0, 16'sh0, 6'd0));
        send_request(make_request(OP_QUERY, 16'h0, 16'sh0, 16'sh0, 6'd1));
        send_request(make_request(OP_ADVANCE, 16'd1, 16'sh0, 16'sh0, 6'd0));
    endtask

    task automatic test_hold_extremes();
        write_hold_time(16'd0);
        send_request(make_request(OP_SCHEDULE, 16'h0, -16'sd1, -16'sd1, 6'd0));
        send_request(make_request(OP_ADVANCE, 16'h0, 16'sh0, 16'sh0, 6'd0));
        write_hold_time(16'hFFFF);
        send_request(make_request(OP_SCHEDULE, 16'h0, 16'sd5, -16'sd5, 6'd0));
        send_request(make_request(OP_ADVANCE, 16'hFFFE, 16'sh0, 16'sh0, 6'd0));
        send_request(make_request(OP_QUERY, 16'h0, 16'sh0, 16'sh0, 6'd0));
        send_request(make_request(OP_ADVANCE, 16'hFFFF, 16'sh0, 16'sh0, 6'd0));
        write_hold_time(16'd1);
        send_request(make_request(OP_SCHEDULE, 16'h0, 16'sd1, 16'sd1, 6'd0));
        send_request(make_request(OP_ADVANCE, 16'h0, 16'sh0, 16'sh0, 6'd0));
        send_request(make_request(OP_ADVANCE, 16'd1, 16'sh0, 16'sh0, 6'd0));
    endtask

    task automatic test_table_full();
        logic signed [COORD_W-1:0] xs [CAPACITY];
        logic signed [COORD_W-1:0] ys [CAPACITY];
        write_hold_time(16'd1000);
        send_request(make_request(OP_ADVANCE, 16'hFFFF, 16'sh0, 16'sh0, 6'd0));
        // low bits of y keep the cells distinct
        for (int i = 0; i < CAPACITY; i++) begin
            xs[i] = COORD_W'($urandom());
            ys[i] = COORD_W'({$urandom_range(0, 1023), 6'(i)});
            send_request(make_request(OP_SCHEDULE, TIME_W'($urandom()), xs[i], ys[i],
                                      IDX_W'($urandom())));
        end
        send_request(make_request(OP_SCHEDULE, 16'h0, xs[0] ^ 16'sd1, ys[0], 6'd0));
        send_request(make_request(OP_SCHEDULE, 16'h0, xs[17], ys[17], 6'd0));
        send_request(make_request(OP_QUERY, 16'h0, 16'sh0, 16'sh0, 6'h3F));
        send_request(make_request(OP_QUERY, 16'h0, 16'sh0, 16'sh0, 6'd0));
        send_request(make_request(OP_ADVANCE, 16'd999, 16'sh0, 16'sh0, 6'd0));
        // sender holds off until the table has answered everything
        wait_results_drained();
        send_request(make_request(OP_ADVANCE, 16'd1, 16'sh0, 16'sh0, 6'd0));
        send_request(make_request(OP_QUERY, 16'h0, 16'sh0, 16'sh0, 6'd0));
    endtask

    task automatic test_random_mix(input int count, input logic [TIME_W-1:0] hold);
        write_hold_time(hold);
        repeat (count) begin
            send_request(random_request());
            if ($urandom_range(0, 19) == 0)
                wait_results_drained();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_pace(19, 84);
        test_empty_and_unused();
        test_schedule_query();
        test_hold_extremes();

        set_pace(84, 19);
        test_table_full();

        set_pace(0, 0);
        test_random_mix(9, 16'd300);
        test_random_mix(5, 16'd1);

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (END_PAUSE) @(posedge aclk);

        $display("Run covered %0d requests (advance, schedule, query, unused code), %0d results",
                 requests_sent, results_seen);
        $display("hold_time written %0d times incl. 0, 1 and 65535; table filled and emptied",
                 hold_writes);
        if (mismatches == 0) begin
            $display("PASS dedup_expiry_timer_table_core");
        end else begin
            $display("FAIL dedup_expiry_timer_table_core");
        end
        $finish;
    end

endmodule
